// ----- hw/rtl/rvmt_pkg.sv -----
// Shared types and constants for the row/vector by 4x4 matrix transform.
// Holds element format, pipeline widths, register codes and reset values.
// No dependencies.
package rvmt_pkg;

    // element format
    localparam int ELEMENT_WIDTH = 16;
    localparam int FRACTION_BITS = 8;
    localparam int FIELD_WIDTH   = 16;   // width of a port field / register lane
    localparam int LANES         = 4;    // columns, one lane each
    localparam int TERMS         = 4;    // products per dot product

    // configuration port
    localparam int CFG_WIDTH   = TERMS * FIELD_WIDTH;
    localparam int CFG_INDEX_W = 2;

    // arithmetic widths
    localparam int PROD_W = 2 * ELEMENT_WIDTH;
    localparam int SUM_W  = PROD_W + $clog2(TERMS);
    localparam int RND_W  = SUM_W + 1;

    localparam logic signed [RND_W-1:0] ROUND_HALF =
        (RND_W'(1) << FRACTION_BITS) >> 1;
    localparam logic signed [RND_W-1:0] SAT_MAX =
        RND_W'((64'd1 << (ELEMENT_WIDTH - 1)) - 64'd1);
    localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);

    // pipeline depth up to the merge input
    localparam int LANE_DEPTH = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RIGHT_ROW_0 = 2'd0,
        REG_RIGHT_ROW_1 = 2'd1,
        REG_RIGHT_ROW_2 = 2'd2,
        REG_RIGHT_ROW_3 = 2'd3
    } cfg_reg_e;

    typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic signed [FIELD_WIDTH-1:0]   field_t;
    typedef logic [CFG_WIDTH-1:0]            row_t;

    typedef struct packed {
        elem_t value;
        logic  clip;
    } lane_result_t;

    // identity row k: 1.0 in lane k
    function automatic row_t identity_row(input int k);
        row_t r;
        r = row_t'(64'd1 << FRACTION_BITS) << (FIELD_WIDTH * k);
        return r;
    endfunction

endpackage

// ----- hw/rtl/row_vector_matrix_transform.sv -----
// Top level of the row by 4x4 matrix transform.
// Instantiates four rvmt_lane columns and rvmt_merge; uses rvmt_pkg.
//
// Usage: load the right-hand matrix through the write port (wr_index k
// takes row k, element j in bits 16j+15..16j, signed Q8.8); after reset
// it is the identity. Present one left row per cycle on left_0..left_3
// with start high; busy never rises, so every start is taken. Each item
// yields one result row on product_0..product_3 with clipped, shown for
// exactly one cycle while done is high. The receiver cannot stall;
// results must be captured on done. Throughput is one item per clock:
// four column lanes each hold four multipliers, so a whole row is
// handled at once, and the pipeline is multiply, sum, round/saturate,
// output register. Results come out in the order items went in. Only
// write the matrix while no item is in flight.
module row_vector_matrix_transform
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // item in
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rvmt_pkg::FIELD_WIDTH-1:0] left_0,
    input  logic signed [rvmt_pkg::FIELD_WIDTH-1:0] left_1,
    input  logic signed [rvmt_pkg::FIELD_WIDTH-1:0] left_2,
    input  logic signed [rvmt_pkg::FIELD_WIDTH-1:0] left_3,
    // result out
    output logic                                   done,
    output logic signed [rvmt_pkg::FIELD_WIDTH-1:0] product_0,
    output logic signed [rvmt_pkg::FIELD_WIDTH-1:0] product_1,
    output logic signed [rvmt_pkg::FIELD_WIDTH-1:0] product_2,
    output logic signed [rvmt_pkg::FIELD_WIDTH-1:0] product_3,
    output logic                                   clipped,
    // matrix write port
    input  logic                                   wr_en,
    input  logic [rvmt_pkg::CFG_INDEX_W-1:0]        wr_index,
    input  logic [rvmt_pkg::CFG_WIDTH-1:0]          wr_data
);

    // right matrix rows
    rvmt_pkg::row_t row_reg [rvmt_pkg::TERMS];

    // valid flags alongside the lane stages
    logic [rvmt_pkg::LANE_DEPTH-1:0] valid_reg;
    logic [rvmt_pkg::LANE_DEPTH-1:0] valid_next;
    logic                            accept;

    rvmt_pkg::elem_t        left_elem [rvmt_pkg::TERMS];
    rvmt_pkg::elem_t        col_elem  [rvmt_pkg::LANES][rvmt_pkg::TERMS];
    rvmt_pkg::lane_result_t lane_res  [rvmt_pkg::LANES];
    rvmt_pkg::field_t       product   [rvmt_pkg::LANES];

    // no back-pressure anywhere: a new item may enter every cycle
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // matrix registers; out-of-list indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rvmt_pkg::TERMS; k++)
            begin
                row_reg[k] <= rvmt_pkg::identity_row(k);
            end
        end
        else if (wr_en)
        begin
            case (rvmt_pkg::cfg_reg_e'(wr_index))
                rvmt_pkg::REG_RIGHT_ROW_0: row_reg[0] <= wr_data;
                rvmt_pkg::REG_RIGHT_ROW_1: row_reg[1] <= wr_data;
                rvmt_pkg::REG_RIGHT_ROW_2: row_reg[2] <= wr_data;
                rvmt_pkg::REG_RIGHT_ROW_3: row_reg[3] <= wr_data;
                default: ;
            endcase
        end
    end

    assign valid_next = {valid_reg[rvmt_pkg::LANE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // narrow elements: only the low ELEMENT_WIDTH bits count
    assign left_elem[0] = left_0[rvmt_pkg::ELEMENT_WIDTH-1:0];
    assign left_elem[1] = left_1[rvmt_pkg::ELEMENT_WIDTH-1:0];
    assign left_elem[2] = left_2[rvmt_pkg::ELEMENT_WIDTH-1:0];
    assign left_elem[3] = left_3[rvmt_pkg::ELEMENT_WIDTH-1:0];

    // column j of the matrix: lane j of every row
    always_comb
    begin
        for (int j = 0; j < rvmt_pkg::LANES; j++)
        begin
            for (int k = 0; k < rvmt_pkg::TERMS; k++)
            begin
                col_elem[j][k] =
                    row_reg[k][rvmt_pkg::FIELD_WIDTH*j +: rvmt_pkg::ELEMENT_WIDTH];
            end
        end
    end

    for (genvar j = 0; j < rvmt_pkg::LANES; j++)
    begin : g_lane
        rvmt_lane u_lane
        (
            .clk    (clk),
            .left   (left_elem),
            .col    (col_elem[j]),
            .result (lane_res[j])
        );
    end

    rvmt_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid_reg[rvmt_pkg::LANE_DEPTH-1]),
        .lane_res (lane_res),
        .product  (product),
        .clipped  (clipped),
        .done     (done)
    );

    assign product_0 = product[0];
    assign product_1 = product[1];
    assign product_2 = product[2];
    assign product_3 = product[3];

endmodule

// ----- hw/rtl/rvmt_lane.sv -----
// One column lane: four multiplies, sum, round to nearest and saturate.
// Three register stages. Depends on rvmt_pkg.
module rvmt_lane
(
    input  logic                  clk,
    input  rvmt_pkg::elem_t       left [rvmt_pkg::TERMS],
    input  rvmt_pkg::elem_t       col  [rvmt_pkg::TERMS],
    output rvmt_pkg::lane_result_t result
);

    logic signed [rvmt_pkg::PROD_W-1:0] prod_reg [rvmt_pkg::TERMS];
    logic signed [rvmt_pkg::SUM_W-1:0]  sum_reg;
    logic signed [rvmt_pkg::SUM_W-1:0]  sum_next;
    logic signed [rvmt_pkg::RND_W-1:0]  rnd;
    logic signed [rvmt_pkg::RND_W-1:0]  shifted;
    rvmt_pkg::lane_result_t             result_reg;
    rvmt_pkg::lane_result_t             result_next;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < rvmt_pkg::TERMS; k++)
        begin
            prod_reg[k] <= left[k] * col[k];
        end
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    // exact sum of the products
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < rvmt_pkg::TERMS; k++)
        begin
            sum_next = sum_next + rvmt_pkg::SUM_W'(prod_reg[k]);
        end
    end

    // round half up, then clamp to the element range
    always_comb
    begin
        rnd     = rvmt_pkg::RND_W'(sum_reg) + rvmt_pkg::ROUND_HALF;
        shifted = rnd >>> rvmt_pkg::FRACTION_BITS;
        if (shifted > rvmt_pkg::SAT_MAX)
        begin
            result_next.value = rvmt_pkg::elem_t'(rvmt_pkg::SAT_MAX);
            result_next.clip  = 1'b1;
        end
        else if (shifted < rvmt_pkg::SAT_MIN)
        begin
            result_next.value = rvmt_pkg::elem_t'(rvmt_pkg::SAT_MIN);
            result_next.clip  = 1'b1;
        end
        else
        begin
            result_next.value = shifted[rvmt_pkg::ELEMENT_WIDTH-1:0];
            result_next.clip  = 1'b0;
        end
    end

    assign result = result_reg;

endmodule

// ----- hw/rtl/rvmt_merge.sv -----
// Merge stage: gathers the lane results, ORs the clip flags, drives outputs.
// Depends on rvmt_pkg.
module rvmt_merge
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    input  rvmt_pkg::lane_result_t lane_res [rvmt_pkg::LANES],
    output rvmt_pkg::field_t       product  [rvmt_pkg::LANES],
    output logic                   clipped,
    output logic                   done
);

    rvmt_pkg::field_t product_reg [rvmt_pkg::LANES];
    logic             clipped_reg;
    logic             clipped_next;
    logic             done_reg;

    always_comb
    begin
        clipped_next = 1'b0;
        for (int j = 0; j < rvmt_pkg::LANES; j++)
        begin
            clipped_next = clipped_next | lane_res[j].clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < rvmt_pkg::LANES; j++)
        begin
            product_reg[j] <= rvmt_pkg::FIELD_WIDTH'(lane_res[j].value);
        end
        clipped_reg <= clipped_next;
    end

    assign product = product_reg;
    assign clipped = clipped_reg;
    assign done    = done_reg;

endmodule
